// ===== sv/gnsa_pkg.sv =====
// Package for the Gaussian noise sample adder: widths, register indexes,
// generator and fixed-point constants, and the per-stage tables of the Horner sine/cosine loop.
// No dependencies.
`default_nettype none

package gnsa_pkg;

	localparam int unsigned SMP_W   = 16;
	localparam int unsigned SCALE_W = 24;
	localparam int unsigned CFG_W   = 32;
	localparam int unsigned IDX_W   = 2;
	localparam int unsigned GAUSS_W = 21;
	localparam int unsigned MUL_W   = 32;

	localparam logic [IDX_W-1:0] REG_NOISE_SCALE = 2'd0;
	localparam logic [IDX_W-1:0] REG_SEED        = 2'd1;

	localparam logic [31:0] SEED_GOLDEN = 32'h9E37_79B9;
	localparam logic [31:0] SEED_MIX1   = 32'h85EB_CA6B;
	localparam logic [31:0] SEED_MIX2   = 32'hC2B2_AE35;

	localparam logic [16:0] TWO_LN2_Q16 = 17'd90852;
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
	localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
	localparam logic [20:0] LOG_TOP_Q16 = 21'd1572864;

	// Horner stages: cosine first (eight), then sine (seven)
	localparam int unsigned NSTAGE     = 15;
	localparam logic [3:0]  COS_LAST   = 4'd7;
	localparam logic [3:0]  STAGE_LAST = 4'd14;

	localparam logic [7:0] DIV_TAB [NSTAGE] = '{
		8'd240, 8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2,
		8'd210, 8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6
	};

	localparam logic [5:0] SH_TAB [NSTAGE] = '{
		6'd38, 6'd38, 6'd38, 6'd37, 6'd36, 6'd35, 6'd34, 6'd32,
		6'd38, 6'd38, 6'd37, 6'd37, 6'd36, 6'd35, 6'd33
	};

	// Reciprocals floor(2^shift / divisor); one correction step restores the exact quotient
	localparam logic [31:0] RCP_TAB [NSTAGE] = '{
		32'((64'd1 << 38) / 240), 32'((64'd1 << 38) / 182), 32'((64'd1 << 38) / 132),
		32'((64'd1 << 37) / 90),  32'((64'd1 << 36) / 56),  32'((64'd1 << 35) / 30),
		32'((64'd1 << 34) / 12),  32'((64'd1 << 32) / 2),
		32'((64'd1 << 38) / 210), 32'((64'd1 << 38) / 156), 32'((64'd1 << 37) / 110),
		32'((64'd1 << 37) / 72),  32'((64'd1 << 36) / 42),  32'((64'd1 << 35) / 20),
		32'((64'd1 << 33) / 6)
	};

endpackage

`default_nettype wire

// ===== sv/gnsa_in_if.sv =====
// Input channel of the noise adder: valid/ready handshake carrying one clean sample word.
// Depends on gnsa_pkg.
`default_nettype none

interface gnsa_in_if import gnsa_pkg::*; ;
	logic                    valid;
	logic                    ready;
	logic signed [SMP_W-1:0] sample_in;
	logic                    last_in;

	modport source (output valid, output sample_in, output last_in, input ready);
	modport sink (input valid, input sample_in, input last_in, output ready);
endinterface

`default_nettype wire

// ===== sv/gnsa_out_if.sv =====
// Output channel of the noise adder: valid/ready handshake carrying one noisy sample word.
// Depends on gnsa_pkg.
`default_nettype none

interface gnsa_out_if import gnsa_pkg::*; ;
	logic                    valid;
	logic                    ready;
	logic signed [SMP_W-1:0] sample_out;
	logic                    last_out;

	modport source (output valid, output sample_out, output last_out, input ready);
	modport sink (input valid, input sample_out, input last_out, output ready);
endinterface

`default_nettype wire

// ===== sv/gnsa_mul.sv =====
// Shared 32x32 unsigned multiplier with a registered product, used for every
// product in the noise adder. Depends on gnsa_pkg.
`default_nettype none

module gnsa_mul import gnsa_pkg::*; (
	input  wire logic               clk,
	input  wire logic [MUL_W-1:0]   a,
	input  wire logic [MUL_W-1:0]   b,
	output logic      [2*MUL_W-1:0] p
);

	logic [2*MUL_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= {{MUL_W{1'b0}}, a} * {{MUL_W{1'b0}}, b};
	end

	assign p = p_q;

endmodule

`default_nettype wire

// ===== sv/gaussian_noise_sample_adder_top.sv =====
// Gaussian noise sample adder: top level with sequencer, generator state and output register.
// Depends on gnsa_pkg, gnsa_in_if, gnsa_out_if and gnsa_mul.
//
// Adds scaled Gaussian noise to each signed 16-bit sample and saturates the sum.
// Noise is Box-Muller over xorshift128; each transform gives one value used at once
// and one cached for the next sample. All products go through one registered
// 32x32 multiplier under a step sequencer, and the block takes one sample at a time.
// A sample served from the cache goes straight to scaling and the sum; a sample
// that runs a fresh transform first passes 16 log squarings, a 20-step square
// root and 15 Horner stages. After reset and after each seed write the block is
// busy while it expands the seed into its four generator words. A finished
// result waits in the output register while the next sample is accepted.
`default_nettype none

module gaussian_noise_sample_adder_top import gnsa_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	gnsa_in_if.sink               sample_ch,
	gnsa_out_if.source            noisy_ch,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_index,
	input  wire logic [CFG_W-1:0] wr_data
);

	typedef enum logic [30:0] {
		ST_SD_A  = 31'd1 << 0,
		ST_SD_B  = 31'd1 << 1,
		ST_SD_C  = 31'd1 << 2,
		ST_SD_D  = 31'd1 << 3,
		ST_SD_E  = 31'd1 << 4,
		ST_IDLE  = 31'd1 << 5,
		ST_GN_A  = 31'd1 << 6,
		ST_GN_B  = 31'd1 << 7,
		ST_LG_N  = 31'd1 << 8,
		ST_LG_M  = 31'd1 << 9,
		ST_LG_U  = 31'd1 << 10,
		ST_LG_X  = 31'd1 << 11,
		ST_SQ_I  = 31'd1 << 12,
		ST_SQ_S  = 31'd1 << 13,
		ST_TH_M  = 31'd1 << 14,
		ST_TH_W  = 31'd1 << 15,
		ST_W_M   = 31'd1 << 16,
		ST_W_W   = 31'd1 << 17,
		ST_H_1   = 31'd1 << 18,
		ST_H_2   = 31'd1 << 19,
		ST_H_3   = 31'd1 << 20,
		ST_H_4   = 31'd1 << 21,
		ST_SN_M  = 31'd1 << 22,
		ST_SN_W  = 31'd1 << 23,
		ST_GA_M  = 31'd1 << 24,
		ST_GA_W  = 31'd1 << 25,
		ST_GB_M  = 31'd1 << 26,
		ST_GB_W  = 31'd1 << 27,
		ST_NZ_A  = 31'd1 << 28,
		ST_NZ_W  = 31'd1 << 29,
		ST_OUT   = 31'd1 << 30
	} state_t;

	state_t                 state_q;
	logic [SCALE_W-1:0]     scale_q;
	logic [31:0]            z_q;
	logic [1:0]             wcnt_q;
	logic [31:0]            words_q [4];
	logic [GAUSS_W-1:0]     spare_q;
	logic                   spare_vld_q;
	logic [SMP_W-1:0]       smp_q;
	logic                   last_q;
	logic [24:0]            v1_q;
	logic [23:0]            ph_q;
	logic [30:0]            m_q;
	logic [20:0]            l_q;
	logic [3:0]             cnt_q;
	logic [38:0]            x_q;
	logic [38:0]            res_q;
	logic [38:0]            bit_q;
	logic [30:0]            theta_q;
	logic [31:0]            w_q;
	logic [30:0]            t_q;
	logic [3:0]             hs_q;
	logic [31:0]            y_q;
	logic [31:0]            q_q;
	logic [30:0]            c_q;
	logic [30:0]            s_q;
	logic [GAUSS_W-1:0]     g_q;
	logic [SMP_W-1:0]       ynew_q;
	logic [SMP_W-1:0]       out_smp_q;
	logic                   out_last_q;
	logic                   out_vld_q;

	logic [MUL_W-1:0]       mul_a;
	logic [MUL_W-1:0]       mul_b;
	logic [2*MUL_W-1:0]     prod;

	logic [31:0]            nw;
	logic [31:0]            xs_t;
	logic [31:0]            mix;
	logic [4:0]             lead;
	logic [30:0]            mnorm;
	logic [31:0]            msq;
	logic [20:0]            dlog;
	logic [39:0]            trial;
	logic [31:0]            q0;
	logic [31:0]            rem;
	logic [31:0]            qf;
	logic [30:0]            tn;
	logic [30:0]            cm;
	logic [30:0]            sm;
	logic                   cn;
	logic                   sn;
	logic [63:0]            grnd;
	logic [GAUSS_W-1:0]     gmag;
	logic [GAUSS_W-1:0]     mg;
	logic [63:0]            nrnd;
	logic [21:0]            nmag;
	logic signed [22:0]     ysum;
	logic [SMP_W-1:0]       ysat;

	gnsa_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	// xorshift128 step
	always_comb begin
		xs_t = words_q[3] ^ (words_q[3] << 11);
		xs_t = xs_t ^ (xs_t >> 8);
		nw   = xs_t ^ words_q[0] ^ (words_q[0] >> 19);
	end

	always_comb begin
		lead = '0;
		for (int i = 0; i < 25; i++) begin
			if (v1_q[i]) begin
				lead = 5'(i);
			end
		end
		mnorm = 31'({6'd0, v1_q} << (5'd30 - lead));
	end

	assign mix   = prod[31:0] ^ (prod[31:0] >> 13);
	assign msq   = prod[61:30];
	assign dlog  = LOG_TOP_Q16 - l_q;
	assign trial = {1'b0, res_q} + {1'b0, bit_q};
	assign q0    = 32'(prod >> SH_TAB[hs_q]);
	assign rem   = y_q - prod[31:0];
	assign qf    = (rem >= {24'd0, DIV_TAB[hs_q]}) ? q_q + 32'd1 : q_q;
	assign tn    = (qf >= {1'b0, ONE_Q30}) ? '0 : 31'({1'b0, ONE_Q30} - qf);

	// quadrant folding
	always_comb begin
		cm = c_q;
		sm = s_q;
		case (ph_q[23:22])
			2'd0: begin
				cm = c_q; cn = 1'b0; sm = s_q; sn = 1'b0;
			end
			2'd1: begin
				cm = s_q; cn = 1'b1; sm = c_q; sn = 1'b0;
			end
			2'd2: begin
				cm = c_q; cn = 1'b1; sm = s_q; sn = 1'b1;
			end
			default: begin
				cm = s_q; cn = 1'b0; sm = c_q; sn = 1'b1;
			end
		endcase
	end

	assign grnd = prod + (64'd1 << 29);
	assign gmag = grnd[50:30];
	assign mg   = g_q[GAUSS_W-1] ? GAUSS_W'(-g_q) : g_q;
	assign nrnd = prod + (64'd1 << 23);
	assign nmag = nrnd[45:24];

	always_comb begin
		if (g_q[GAUSS_W-1]) begin
			ysum = 23'(signed'(smp_q)) - signed'({1'b0, nmag});
		end else begin
			ysum = 23'(signed'(smp_q)) + signed'({1'b0, nmag});
		end
		if (ysum > 23'sd32767) begin
			ysat = 16'h7FFF;
		end else if (ysum < -23'sd32768) begin
			ysat = 16'h8000;
		end else begin
			ysat = ysum[15:0];
		end
	end

	// operand selection for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SD_B: begin
				mul_a = z_q ^ (z_q >> 16);
				mul_b = SEED_MIX1;
			end
			ST_SD_C: begin
				mul_a = mix;
				mul_b = SEED_MIX2;
			end
			ST_LG_M: begin
				mul_a = {1'b0, m_q};
				mul_b = {1'b0, m_q};
			end
			ST_LG_X: begin
				mul_a = {11'd0, dlog};
				mul_b = {15'd0, TWO_LN2_Q16};
			end
			ST_TH_M: begin
				mul_a = {10'd0, ph_q[21:0]};
				mul_b = HALF_PI_Q30;
			end
			ST_W_M: begin
				mul_a = {1'b0, theta_q};
				mul_b = {1'b0, theta_q};
			end
			ST_H_1: begin
				mul_a = w_q;
				mul_b = {1'b0, t_q};
			end
			ST_H_2: begin
				mul_a = prod[61:30];
				mul_b = RCP_TAB[hs_q];
			end
			ST_H_3: begin
				mul_a = q0;
				mul_b = {24'd0, DIV_TAB[hs_q]};
			end
			ST_SN_M: begin
				mul_a = {1'b0, theta_q};
				mul_b = {1'b0, t_q};
			end
			ST_GA_M: begin
				mul_a = {12'd0, res_q[19:0]};
				mul_b = {1'b0, cm};
			end
			ST_GB_M: begin
				mul_a = {12'd0, res_q[19:0]};
				mul_b = {1'b0, sm};
			end
			ST_NZ_A: begin
				mul_a = {11'd0, mg};
				mul_b = {8'd0, scale_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SD_A;
			scale_q     <= '0;
			z_q         <= '0;
			wcnt_q      <= '0;
			spare_vld_q <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			// load a new word, or drop the one taken by the sink
			if (state_q == ST_OUT && (!out_vld_q || noisy_ch.ready)) begin
				out_vld_q <= 1'b1;
			end else if (noisy_ch.valid && noisy_ch.ready) begin
				out_vld_q <= 1'b0;
			end
			if (wr_en && wr_index == REG_NOISE_SCALE) begin
				scale_q <= wr_data[SCALE_W-1:0];
			end
			if (wr_en && wr_index == REG_SEED) begin
				z_q     <= wr_data;
				wcnt_q  <= '0;
				state_q <= ST_SD_A;
			end else begin
				case (state_q)
					ST_SD_A: begin
						z_q     <= z_q + SEED_GOLDEN;
						state_q <= ST_SD_B;
					end
					ST_SD_B: state_q <= ST_SD_C;
					ST_SD_C: state_q <= ST_SD_D;
					ST_SD_D: begin
						wcnt_q  <= wcnt_q + 2'd1;
						state_q <= (wcnt_q == 2'd3) ? ST_SD_E : ST_SD_A;
					end
					ST_SD_E: begin
						spare_vld_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
					ST_IDLE: begin
						if (sample_ch.valid) begin
							if (spare_vld_q) begin
								spare_vld_q <= 1'b0;
								state_q     <= ST_NZ_A;
							end else begin
								state_q <= ST_GN_A;
							end
						end
					end
					ST_GN_A: state_q <= ST_GN_B;
					ST_GN_B: state_q <= ST_LG_N;
					ST_LG_N: state_q <= ST_LG_M;
					ST_LG_M: state_q <= ST_LG_U;
					ST_LG_U: state_q <= (cnt_q == 4'd0) ? ST_LG_X : ST_LG_M;
					ST_LG_X: state_q <= ST_SQ_I;
					ST_SQ_I: state_q <= ST_SQ_S;
					ST_SQ_S: begin
						if (bit_q[0]) begin
							state_q <= ST_TH_M;
						end
					end
					ST_TH_M: state_q <= ST_TH_W;
					ST_TH_W: state_q <= ST_W_M;
					ST_W_M:  state_q <= ST_W_W;
					ST_W_W:  state_q <= ST_H_1;
					ST_H_1:  state_q <= ST_H_2;
					ST_H_2:  state_q <= ST_H_3;
					ST_H_3:  state_q <= ST_H_4;
					ST_H_4:  state_q <= (hs_q == STAGE_LAST) ? ST_SN_M : ST_H_1;
					ST_SN_M: state_q <= ST_SN_W;
					ST_SN_W: state_q <= ST_GA_M;
					ST_GA_M: state_q <= ST_GA_W;
					ST_GA_W: state_q <= ST_GB_M;
					ST_GB_M: state_q <= ST_GB_W;
					ST_GB_W: begin
						spare_vld_q <= 1'b1;
						state_q     <= ST_NZ_A;
					end
					ST_NZ_A: state_q <= ST_NZ_W;
					ST_NZ_W: state_q <= ST_OUT;
					ST_OUT: begin
						// hold until the output register is free
						if (!out_vld_q || noisy_ch.ready) begin
							state_q <= ST_IDLE;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_SD_D: words_q[wcnt_q] <= prod[31:0] ^ (prod[31:0] >> 16);
			ST_SD_E: begin
				if ((words_q[0] | words_q[1] | words_q[2] | words_q[3]) == 32'd0) begin
					words_q[0] <= 32'd1;
				end
				spare_q <= '0;
			end
			ST_IDLE: begin
				smp_q  <= sample_ch.sample_in;
				last_q <= sample_ch.last_in;
				g_q    <= spare_q;
			end
			ST_GN_A, ST_GN_B: begin
				words_q[3] <= words_q[2];
				words_q[2] <= words_q[1];
				words_q[1] <= words_q[0];
				words_q[0] <= nw;
				if (state_q == ST_GN_A) begin
					v1_q <= {1'b0, nw[31:8]} + 25'd1;
				end else begin
					ph_q <= nw[31:8] + 24'd1;
				end
			end
			ST_LG_N: begin
				m_q   <= mnorm;
				l_q   <= {lead, 16'd0};
				cnt_q <= 4'd15;
			end
			ST_LG_U: begin
				if (msq[31]) begin
					l_q[cnt_q] <= 1'b1;
					m_q        <= msq[31:1];
				end else begin
					m_q <= msq[30:0];
				end
				cnt_q <= cnt_q - 4'd1;
			end
			ST_SQ_I: begin
				x_q   <= prod[38:0];
				res_q <= '0;
				bit_q <= 39'd1 << 38;
			end
			ST_SQ_S: begin
				if ({1'b0, x_q} >= trial) begin
					x_q   <= x_q - trial[38:0];
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_TH_W: theta_q <= prod[52:22];
			ST_W_W: begin
				w_q  <= prod[61:30];
				t_q  <= ONE_Q30;
				hs_q <= '0;
			end
			ST_H_2: y_q <= prod[61:30];
			ST_H_3: q_q <= q0;
			ST_H_4: begin
				// end of the cosine run: keep it and restart for sine
				if (hs_q == COS_LAST) begin
					c_q <= tn;
					t_q <= ONE_Q30;
				end else begin
					t_q <= tn;
				end
				hs_q <= hs_q + 4'd1;
			end
			ST_SN_W: s_q <= prod[60:30];
			ST_GA_W: g_q <= cn ? GAUSS_W'(-gmag) : gmag;
			ST_GB_W: spare_q <= sn ? GAUSS_W'(-gmag) : gmag;
			ST_NZ_W: ynew_q <= ysat;
			ST_OUT: begin
				if (!out_vld_q || noisy_ch.ready) begin
					out_smp_q  <= ynew_q;
					out_last_q <= last_q;
				end
			end
			default: ;
		endcase
	end

	assign sample_ch.ready     = (state_q == ST_IDLE);
	assign noisy_ch.valid      = out_vld_q;
	assign noisy_ch.sample_out = signed'(out_smp_q);
	assign noisy_ch.last_out   = out_last_q;

endmodule

`default_nettype wire
